### rtl/rgbe_pkg.sv
// rgbe_pkg: shared types and constants for the RGBE run-length scanline decoder.
// No dependencies.
package rgbe_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        pixel_valid;
    logic [31:0] red_value;
    logic [31:0] green_value;
    logic [31:0] blue_value;
    logic [7:0]  exponent_byte;
    logic        line_ready;
    logic        last_in_line;
    logic        image_done;
  } out_beat_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_WID  = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_BUSY = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam int EXP_BIAS = 136;

  // IEEE single bits of m * 2^sh, exact for m in 0..255, sh in -135..119
  function automatic logic [31:0] fbits(input logic [7:0] m, input logic signed [9:0] sh);
    logic [2:0] p;
    logic signed [10:0] e;
    logic [31:0] r;
    logic signed [10:0] s;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (m[i]) p = 3'(i);
    end
    e = 11'(signed'({1'b0, p})) + 11'(sh) + 11'sd127;
    r = 32'd0;
    if (m != 8'd0) begin
      if (e >= 11'sd1) begin
        r = {1'b0, e[7:0], 23'((({15'd0, m} << (5'd23 - 5'(p)))) & 23'h7fffff)};
      end else begin
        s = 11'(sh) + 11'sd149;
        r = {24'd0, m} << s[4:0];
      end
    end
    return r;
  endfunction

endpackage

### rtl/rgbe_rle_scanline_decoder.sv
// rgbe_rle_scanline_decoder: RGBE run-length scanline decoder, top level.
// Depends on rgbe_pkg and rgbe_ram (line store).
//
//   channel | signals                       | payload
//   in      | in_valid, in_ready            | rgbe_pkg::in_beat_t
//   out     | out_valid, out_ready          | rgbe_pkg::out_beat_t
//   cfg     | psel penable pwrite paddr ... | 32-bit registers at 0,4,8
//
// Each beat passes through S_STEP and S_OUT; a run byte also passes S_RUN, one
// store entry a cycle, a literal byte writes one entry there, and a pixel read
// passes S_RD (four planes through the single read port).
// After reset or a width/height write the decoder is armed; no clearing pass.
// The output register holds a result while out_ready is low; input stalls then.
module rgbe_rle_scanline_decoder #(
  parameter int MAX_WIDTH = 8192
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgbe_pkg::in_beat_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rgbe_pkg::out_beat_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  localparam int PW = $clog2(MAX_WIDTH);
  localparam int AW = PW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_MARK = 3'd3;
  localparam logic [2:0] PH_CNT  = 3'd4;
  localparam logic [2:0] PH_RUNB = 3'd5;
  localparam logic [2:0] PH_LIT  = 3'd6;
  localparam logic [2:0] PH_RDY  = 3'd7;

  logic [13:0] scanline_width, scanline_width_next;
  logic [14:0] image_height, image_height_next;
  logic        decode_mode, decode_mode_next;

  logic [2:0]  state, state_next;
  logic [2:0]  decode_phase, decode_phase_next;
  logic [1:0]  plane_index, plane_index_next;
  logic [13:0] plane_position, plane_position_next;
  logic [7:0]  group_count, group_count_next;
  logic [31:0] header_bytes, header_bytes_next;
  logic [14:0] lines_left, lines_left_next;
  logic [27:0] raw_pixels_left, raw_pixels_left_next;
  logic        raw_fallback, raw_fallback_next;
  logic [13:0] readout_index, readout_index_next;
  logic [1:0]  error_flag, error_flag_next;
  logic [13:0] raw_col, raw_col_next;
  logic [7:0]  run_byte;
  logic [2:0]  rd_cnt, rd_cnt_next;
  logic [7:0]  pix [3];
  rgbe_pkg::in_beat_t  cur;
  rgbe_pkg::out_beat_t res, res_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;

  rgbe_ram #(.WIDTH(8), .DEPTH(4 * MAX_WIDTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(run_byte),
    .raddr(raddr), .rdata(rdata)
  );

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      rgbe_pkg::REG_WIDTH:  prdata = {18'd0, scanline_width};
      rgbe_pkg::REG_HEIGHT: prdata = {17'd0, image_height};
      rgbe_pkg::REG_MODE:   prdata = {31'd0, decode_mode};
      default:              prdata = 32'd0;
    endcase
  end

  logic        cfg_arm;
  logic [13:0] cfg_w;
  logic [14:0] cfg_h;
  logic [27:0] arm_pixels, rest_pixels;
  assign cfg_arm = cfg_wr && (paddr[3:2] == rgbe_pkg::REG_WIDTH ||
                              paddr[3:2] == rgbe_pkg::REG_HEIGHT);
  assign cfg_w = (paddr[3:2] == rgbe_pkg::REG_WIDTH) ? pwdata[13:0] : scanline_width;
  assign cfg_h = (paddr[3:2] == rgbe_pkg::REG_HEIGHT) ? pwdata[14:0] : image_height;
  assign arm_pixels  = 28'(cfg_w) * 28'(cfg_h);
  assign rest_pixels = 28'(scanline_width) * 28'(lines_left);

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;
  assign we    = (state == S_RUN);
  assign waddr = {plane_index, plane_position[PW-1:0]};
  assign raddr = {rd_cnt[1:0], readout_index[PW-1:0]};

  logic is_done;
  assign is_done = raw_fallback ? (raw_pixels_left == 28'd0) : (lines_left == 15'd0);
  logic over_max;
  assign over_max = ({1'b0, scanline_width} > 15'(MAX_WIDTH));

  logic [13:0] pos_inc;
  logic        plane_end;
  assign pos_inc   = plane_position + 14'd1;
  assign plane_end = (pos_inc >= scanline_width);
  logic [14:0] room;
  assign room = {1'b0, scanline_width} - {1'b0, plane_position};
  logic        is_run;
  logic [7:0]  cval;
  assign is_run = (cur.data_byte > 8'd128);
  assign cval = is_run ? (cur.data_byte - 8'd128) : cur.data_byte;

  logic [13:0] raw_col_inc;
  logic        raw_end;
  assign raw_col_inc = raw_col + 14'd1;
  assign raw_end = (raw_col_inc >= scanline_width);
  logic [13:0] readout_inc;
  assign readout_inc = readout_index + 14'd1;

  logic [31:0] hnext;
  assign hnext = {header_bytes[23:0], cur.data_byte};

  function automatic rgbe_pkg::out_beat_t mkpix(input logic [7:0] r, input logic [7:0] g,
      input logic [7:0] b, input logic [7:0] e, input logic scale);
    rgbe_pkg::out_beat_t o;
    logic signed [9:0] sh;
    o = '0;
    o.pixel_valid = 1'b1;
    o.exponent_byte = e;
    sh = scale ? (10'(signed'({2'b0, e})) - 10'sd136) : 10'sd0;
    if (!(scale && e == 8'd0)) begin
      o.red_value   = rgbe_pkg::fbits(r, sh);
      o.green_value = rgbe_pkg::fbits(g, sh);
      o.blue_value  = rgbe_pkg::fbits(b, sh);
    end
    return o;
  endfunction

  always_comb begin
    scanline_width_next  = scanline_width;
    image_height_next    = image_height;
    decode_mode_next     = decode_mode;
    state_next           = state;
    decode_phase_next    = decode_phase;
    plane_index_next     = plane_index;
    plane_position_next  = plane_position;
    group_count_next     = group_count;
    header_bytes_next    = header_bytes;
    lines_left_next      = lines_left;
    raw_pixels_left_next = raw_pixels_left;
    raw_fallback_next    = raw_fallback;
    readout_index_next   = readout_index;
    error_flag_next      = error_flag;
    raw_col_next         = raw_col;
    rd_cnt_next          = rd_cnt;
    res_next             = res;
    if (cfg_wr && paddr[3:2] == rgbe_pkg::REG_MODE) decode_mode_next = pwdata[0];
    if (cfg_arm) begin
      scanline_width_next = cfg_w; image_height_next = cfg_h;
      decode_phase_next = PH_HDR; plane_index_next = 2'd0; plane_position_next = 14'd0;
      group_count_next = 8'd0; header_bytes_next = 32'd0; readout_index_next = 14'd0;
      error_flag_next = 2'd0; lines_left_next = cfg_h; raw_fallback_next = (cfg_w < 14'd8);
      raw_pixels_left_next = (cfg_w < 14'd8) ? arm_pixels : 28'd0;
      raw_col_next = 14'd0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state_next = S_STEP;
        S_STEP: begin
          res_next = '0;
          state_next = S_OUT;
          if (error_flag != 2'd0) begin
            res_next.status = error_flag;
          end else if (is_done) begin
            res_next.status = rgbe_pkg::ST_BUSY;
            res_next.image_done = 1'b1;
          end else if (cur.kind) begin
            if (!raw_fallback && decode_phase == PH_RDY && readout_index < scanline_width
                && {1'b0, readout_index} < 15'(MAX_WIDTH)) begin
              rd_cnt_next = 3'd0;
              state_next = S_RD;
            end else begin
              res_next.status = rgbe_pkg::ST_BUSY;
              res_next.line_ready = !raw_fallback && decode_phase == PH_RDY;
            end
          end else if (raw_fallback) begin
            header_bytes_next = hnext;
            if (decode_phase == PH_MARK) begin
              decode_phase_next = PH_HDR; header_bytes_next = 32'd0;
              res_next = mkpix(hnext[31:24], hnext[23:16], hnext[15:8], hnext[7:0], 1'b1);
              raw_pixels_left_next = raw_pixels_left - 28'd1;
              raw_col_next = raw_end ? 14'd0 : raw_col_inc;
              res_next.last_in_line = raw_end;
              res_next.image_done = (raw_pixels_left == 28'd1);
            end else begin
              decode_phase_next = decode_phase + 3'd1;
            end
          end else if (decode_phase <= PH_MARK) begin
            header_bytes_next = hnext;
            if (decode_phase < PH_MARK) begin
              decode_phase_next = decode_phase + 3'd1;
            end else begin
              header_bytes_next = 32'd0; decode_phase_next = PH_HDR;
              if (hnext[31:24] != 8'd2 || hnext[23:16] != 8'd2 || hnext[15]) begin
                res_next = mkpix(hnext[31:24], hnext[23:16], hnext[15:8], hnext[7:0], 1'b1);
                raw_fallback_next = 1'b1;
                raw_pixels_left_next = rest_pixels - 28'd1;
                raw_col_next = (scanline_width == 14'd1) ? 14'd0 : 14'd1;
                res_next.last_in_line = (scanline_width == 14'd1);
                res_next.image_done = (rest_pixels == 28'd1);
              end else if (hnext[15:0] != {2'b0, scanline_width} || over_max) begin
                error_flag_next = rgbe_pkg::ST_WID;
                res_next.status = rgbe_pkg::ST_WID;
              end else begin
                decode_phase_next = PH_CNT; plane_index_next = 2'd0;
                plane_position_next = 14'd0;
              end
            end
          end else if (decode_phase == PH_CNT) begin
            if (cval == 8'd0 || {7'd0, cval} > room) begin
              error_flag_next = rgbe_pkg::ST_RUN;
              res_next.status = rgbe_pkg::ST_RUN;
            end else begin
              group_count_next = cval;
              decode_phase_next = is_run ? PH_RUNB : PH_LIT;
            end
          end else if (decode_phase == PH_RUNB || decode_phase == PH_LIT) begin
            if (decode_phase == PH_LIT) group_count_next = group_count - 8'd1;
            state_next = S_RUN;
          end else begin
            res_next.status = rgbe_pkg::ST_BUSY;
            res_next.line_ready = 1'b1;
          end
        end
        S_RUN: begin
          if (decode_phase == PH_RUNB) group_count_next = group_count - 8'd1;
          if (plane_end) begin
            plane_position_next = 14'd0;
            plane_index_next = plane_index + 2'd1;
          end else begin
            plane_position_next = pos_inc;
          end
          if ((decode_phase == PH_RUNB && group_count == 8'd1) || decode_phase == PH_LIT) begin
            state_next = S_OUT;
            res_next = '0;
            if (decode_phase == PH_RUNB || group_count == 8'd0) decode_phase_next = PH_CNT;
            if (decode_phase == PH_RUNB) group_count_next = 8'd0;
            if (plane_end && plane_index == 2'd3) begin
              decode_phase_next = PH_RDY;
              readout_index_next = 14'd0;
              res_next.line_ready = 1'b1;
            end
          end
        end
        S_RD: begin
          rd_cnt_next = rd_cnt + 3'd1;
          if (rd_cnt == 3'd4) begin
            res_next = mkpix(pix[0], pix[1], pix[2], rdata, decode_mode);
            state_next = S_OUT;
            if (readout_inc >= scanline_width) begin
              readout_index_next = 14'd0;
              decode_phase_next = PH_HDR;
              lines_left_next = lines_left - 15'd1;
              res_next.last_in_line = 1'b1;
              res_next.image_done = (lines_left == 15'd1);
            end else begin
              readout_index_next = readout_inc;
              res_next.line_ready = 1'b1;
            end
          end
        end
        S_OUT: if (out_ready) state_next = S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanline_width <= 14'd8;
      image_height <= 15'd1;
      decode_mode <= 1'b1;
      state <= S_IDLE;
      decode_phase <= PH_HDR; plane_index <= 2'd0; plane_position <= 14'd0;
      group_count <= 8'd0; header_bytes <= 32'd0; readout_index <= 14'd0;
      error_flag <= 2'd0; lines_left <= 15'd1; raw_fallback <= 1'b0;
      raw_pixels_left <= 28'd0; raw_col <= 14'd0; rd_cnt <= 3'd0;
      res <= '0;
    end else begin
      scanline_width <= scanline_width_next;
      image_height <= image_height_next;
      decode_mode <= decode_mode_next;
      state <= state_next;
      decode_phase <= decode_phase_next;
      plane_index <= plane_index_next;
      plane_position <= plane_position_next;
      group_count <= group_count_next;
      header_bytes <= header_bytes_next;
      readout_index <= readout_index_next;
      error_flag <= error_flag_next;
      lines_left <= lines_left_next;
      raw_fallback <= raw_fallback_next;
      raw_pixels_left <= raw_pixels_left_next;
      raw_col <= raw_col_next;
      rd_cnt <= rd_cnt_next;
      res <= res_next;
    end
  end

  // input beat, store write byte, and plane bytes gathered during a pixel read
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) cur <= in_data;
    if (state == S_STEP) run_byte <= cur.data_byte;
    if (state == S_RD && rd_cnt != 3'd0 && rd_cnt != 3'd4) pix[rd_cnt[1:0] - 2'd1] <= rdata;
  end

  assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pixel_valid == 1'b0 |-> out_data.red_value == 32'd0)
    else $error("payload on empty result");
  assert property (@(posedge clk) disable iff (rst)
    error_flag != 2'd0 && out_valid |-> out_data.status == error_flag)
    else $error("sticky error not reported");
  assert property (@(posedge clk) disable iff (rst)
    we |-> !raw_fallback)
    else $error("store write in raw mode");
endmodule

### rtl/rgbe_ram.sv
// rgbe_ram: generic single-port write, single-port read RAM, registered read.
// No dependencies.
module rgbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### tb/tb_rgbe_rle_scanline_decoder.sv
// Testbench for rgbe_rle_scanline_decoder: drives run-length and raw RGBE byte streams,
// predicts every result beat with an in-bench decoder model and compares field by field.
// Depends on rgbe_pkg and the decoder RTL.
module tb_rgbe_rle_scanline_decoder;

  localparam int MAXW = 8192;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  rgbe_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rgbe_pkg::out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rgbe_rle_scanline_decoder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // decoder shadow state
  localparam logic [2:0] PH_READY = 3'd7;
  logic [13:0] line_width;
  logic [14:0] img_height;
  logic        scale_mode;
  logic [7:0]  plane_mem [0:4*MAXW-1];
  logic [2:0]  phase;
  int unsigned plane_no, plane_pos, grp_left, rd_pos;
  logic [31:0] hdr_shift;
  logic [14:0] lines_left;
  logic [27:0] raw_left;
  logic        raw_mode;
  logic [1:0]  sticky_err;

  rgbe_pkg::in_beat_t  pending_beats[$];
  rgbe_pkg::out_beat_t expected_pixels[$];
  int errors = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  bit no_gaps = 0;
  bit out_no_stall = 0;

  function automatic logic [31:0] to_single(int unsigned m, int sh);
    int p;
    int e;
    logic [31:0] mm;
    mm = m;
    if (m == 0) return 32'd0;
    p = 7;
    while (mm[p] == 1'b0) p--;
    e = p + sh + 127;
    if (e >= 1) return (32'(e) << 23) | ((mm << (23 - p)) & 32'h7fffff);
    return mm << (sh + 149);
  endfunction

  function automatic void load_pixel(inout rgbe_pkg::out_beat_t o,
                                     input int unsigned r, g, b, e, input bit scale);
    int sh;
    sh = 0;
    o.pixel_valid = 1'b1;
    o.exponent_byte = e[7:0];
    if (scale) begin
      if (e == 0) return;
      sh = int'(e) - rgbe_pkg::EXP_BIAS;
    end
    o.red_value = to_single(r, sh);
    o.green_value = to_single(g, sh);
    o.blue_value = to_single(b, sh);
  endfunction

  function automatic void arm_decoder();
    phase = 3'd0; plane_no = 0; plane_pos = 0; grp_left = 0; hdr_shift = '0;
    rd_pos = 0; sticky_err = 2'd0;
    lines_left = img_height;
    raw_mode = line_width < 8;
    raw_left = raw_mode ? 28'(32'(line_width) * 32'(img_height)) : 28'd0;
  endfunction

  function automatic bit image_finished();
    return raw_mode ? (raw_left == 0) : (lines_left == 0);
  endfunction

  function automatic void put_plane_byte(logic [7:0] v);
    if (plane_no < 4 && plane_pos < MAXW) plane_mem[plane_no * MAXW + plane_pos] = v;
    plane_pos++;
    if (plane_pos >= line_width) begin
      plane_pos = 0;
      plane_no++;
      if (plane_no >= 4) begin
        plane_no = 0;
        phase = PH_READY;
        rd_pos = 0;
      end
    end
  endfunction

  function automatic void write_reg(logic [1:0] idx, logic [31:0] v);
    case (idx)
      rgbe_pkg::REG_WIDTH: begin
        line_width = v[13:0];
        arm_decoder();
      end
      rgbe_pkg::REG_HEIGHT: begin
        img_height = v[14:0];
        arm_decoder();
      end
      rgbe_pkg::REG_MODE: scale_mode = v[0];
      default: ;
    endcase
  endfunction

  function automatic rgbe_pkg::out_beat_t decode_beat(rgbe_pkg::in_beat_t it);
    rgbe_pkg::out_beat_t o;
    logic [1:0] st;
    int unsigned c, room, b0, b1, b2, b3;
    o = '0;
    st = rgbe_pkg::ST_OK;
    if (sticky_err != 0) begin
      st = sticky_err;
    end else if (image_finished()) begin
      st = rgbe_pkg::ST_BUSY;
    end else if (it.kind) begin
      if (!raw_mode && phase == PH_READY && rd_pos < line_width && rd_pos < MAXW) begin
        load_pixel(o, plane_mem[rd_pos], plane_mem[MAXW + rd_pos],
                   plane_mem[2*MAXW + rd_pos], plane_mem[3*MAXW + rd_pos], scale_mode);
        rd_pos++;
        if (rd_pos >= line_width) begin
          o.last_in_line = 1'b1;
          rd_pos = 0;
          phase = 3'd0;
          lines_left = lines_left - 15'd1;
        end
      end else begin
        st = rgbe_pkg::ST_BUSY;
      end
    end else if (raw_mode) begin
      hdr_shift = {hdr_shift[23:0], it.data_byte};
      phase = phase + 3'd1;
      if (phase >= 4) begin
        phase = 3'd0;
        load_pixel(o, hdr_shift[31:24], hdr_shift[23:16], hdr_shift[15:8], hdr_shift[7:0], 1);
        hdr_shift = '0;
        raw_left = raw_left - 28'd1;
        if (line_width != 0 && raw_left % line_width == 0) o.last_in_line = 1'b1;
      end
    end else if (phase <= 3) begin
      hdr_shift = {hdr_shift[23:0], it.data_byte};
      if (phase < 3) begin
        phase++;
      end else begin
        b0 = hdr_shift[31:24]; b1 = hdr_shift[23:16]; b2 = hdr_shift[15:8]; b3 = hdr_shift[7:0];
        hdr_shift = '0;
        phase = 3'd0;
        if (b0 != 2 || b1 != 2 || b2 >= 8'h80) begin
          load_pixel(o, b0, b1, b2, b3, 1);
          raw_mode = 1'b1;
          raw_left = 28'(32'(line_width) * 32'(lines_left) - 1);
          if (raw_left % line_width == 0) o.last_in_line = 1'b1;
        end else if (((b2 << 8) | b3) != line_width || line_width > MAXW) begin
          sticky_err = rgbe_pkg::ST_WID;
        end else begin
          phase = 3'd4;
          plane_no = 0;
          plane_pos = 0;
        end
      end
    end else if (phase == 4) begin
      room = line_width - plane_pos;
      c = (it.data_byte > 128) ? it.data_byte - 128 : it.data_byte;
      if (c == 0 || c > room) begin
        sticky_err = rgbe_pkg::ST_RUN;
      end else begin
        grp_left = c;
        phase = (it.data_byte > 128) ? 3'd5 : 3'd6;
      end
    end else if (phase == 5) begin
      c = grp_left;
      phase = 3'd4;
      grp_left = 0;
      repeat (c) put_plane_byte(it.data_byte);
    end else if (phase == 6) begin
      grp_left = (grp_left - 1) & 8'hff;
      if (grp_left == 0) phase = 3'd4;
      put_plane_byte(it.data_byte);
    end else begin
      st = rgbe_pkg::ST_BUSY;
    end
    if (sticky_err != 0) begin
      st = sticky_err;
      o.line_ready = 1'b0;
      o.image_done = 1'b0;
    end else begin
      o.line_ready = !raw_mode && phase == PH_READY && !image_finished();
      o.image_done = image_finished();
    end
    o.status = st;
    return o;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst && (!in_valid || in_ready)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        in_data <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (no_gaps) gap_left <= 0;
        else if ($urandom_range(9) < 6) gap_left <= 0;
        else if ($urandom_range(9) < 8) gap_left <= $urandom_range(3, 1);
        else gap_left <= $urandom_range(40, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_pixels.push_back(decode_beat(in_data));
  end

  // receiver
  always @(posedge clk) begin
    if (rst || out_no_stall) out_ready <= 1'b1;
    else if ($urandom_range(9) < 7) out_ready <= 1'b1;
    else if ($urandom_range(9) < 9) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(30) == 0);
  end

  always @(posedge clk) begin
    rgbe_pkg::out_beat_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        w = expected_pixels.pop_front();
        if (out_data.status !== w.status)
          report("status", 32'(out_data.status), 32'(w.status));
        if (out_data.pixel_valid !== w.pixel_valid)
          report("pixel_valid", 32'(out_data.pixel_valid), 32'(w.pixel_valid));
        if (out_data.red_value !== w.red_value) report("red", out_data.red_value, w.red_value);
        if (out_data.green_value !== w.green_value)
          report("green", out_data.green_value, w.green_value);
        if (out_data.blue_value !== w.blue_value)
          report("blue", out_data.blue_value, w.blue_value);
        if (out_data.exponent_byte !== w.exponent_byte)
          report("exponent", 32'(out_data.exponent_byte), 32'(w.exponent_byte));
        if (out_data.line_ready !== w.line_ready)
          report("line_ready", 32'(out_data.line_ready), 32'(w.line_ready));
        if (out_data.last_in_line !== w.last_in_line)
          report("last_in_line", 32'(out_data.last_in_line), 32'(w.last_in_line));
        if (out_data.image_done !== w.image_done)
          report("image_done", 32'(out_data.image_done), 32'(w.image_done));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("rgbe_rle_scanline_decoder: mismatch");
      $finish;
    end
  end

  int beats_sent = 0;

  task automatic push_byte(logic [7:0] b);
    pending_beats.push_back('{kind: 1'b0, data_byte: b});
    beats_sent++;
  endtask

  task automatic push_read();
    pending_beats.push_back('{kind: 1'b1, data_byte: 8'($urandom)});
    beats_sent++;
  endtask

  function automatic logic [7:0] pick_value();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_pixels.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    write_reg(idx, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic setup_image(int w, int h, bit m);
    wait_idle();
    apb_write(rgbe_pkg::REG_MODE, 32'(m));
    apb_write(rgbe_pkg::REG_WIDTH, w);
    apb_write(rgbe_pkg::REG_HEIGHT, h);
  endtask

  // flaw: 0 clean, 1 bad run count somewhere in the line
  task automatic push_rle_line(int w, int hdr_w, bit flaw);
    int pos, rem, c, bad_at;
    push_byte(8'd2); push_byte(8'd2);
    push_byte(8'(hdr_w >> 8)); push_byte(8'(hdr_w));
    bad_at = flaw ? $urandom_range(3) : -1;
    for (int pl = 0; pl < 4; pl++) begin
      pos = 0;
      while (pos < w) begin
        rem = w - pos;
        if (pl == bad_at) begin
          case ($urandom_range(2))
            0: push_byte(8'd0);
            1: push_byte(8'd128);
            default: push_byte(rem < 127 ? 8'(128 + rem + 1) : 8'd0);
          endcase
          return;
        end
        if ($urandom_range(1)) begin
          c = $urandom_range(rem < 127 ? rem : 127, 1);
          push_byte(8'(128 + c));
          push_byte(pick_value());
        end else begin
          c = $urandom_range(rem < 128 ? rem : 128, 1);
          push_byte(8'(c));
          repeat (c) push_byte(pick_value());
        end
        pos += c;
      end
    end
    if ($urandom_range(3) == 0) push_byte(8'($urandom));
    repeat (w) begin
      push_read();
      if ($urandom_range(40) == 0) push_byte(8'($urandom));
    end
  endtask

  task automatic run_image(int w, int h);
    int k;
    if (w < 8) begin
      repeat (4 * w * h) push_byte(8'($urandom));
    end else begin
      for (int l = 0; l < h; l++) begin
        if ($urandom_range(6) == 0) push_read();
        k = $urandom_range(24);
        if (k == 0) begin
          push_rle_line(w, w ^ (1 << $urandom_range(7)), 0);
          break;
        end else if (k == 1) begin
          push_rle_line(w, w, 1);
          break;
        end else if (k == 2) begin
          push_byte(8'($urandom_range(255, 3)));
          repeat (4 * (w * (h - l)) - 1) push_byte(8'($urandom));
          break;
        end
        push_rle_line(w, w, 0);
      end
    end
    push_read();
    push_byte(8'($urandom));
  endtask

  initial begin
    int w, h;
    line_width = 14'd8; img_height = 15'd1; scale_mode = 1'b1;
    foreach (plane_mem[i]) plane_mem[i] = 8'd0;
    arm_decoder();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: one line with runs, literals and exponent extremes, then mode 0
    setup_image(8, 2, 1);
    push_read();
    push_byte(8'd2); push_byte(8'd2); push_byte(8'd0); push_byte(8'd8);
    push_byte(8'd136); push_byte(8'hff);
    push_byte(8'd8); push_byte(8'd0); push_byte(8'd1); push_byte(8'd2); push_byte(8'h7f);
    push_byte(8'h80); push_byte(8'hc3); push_byte(8'hfe); push_byte(8'hff);
    push_byte(8'd136); push_byte(8'h80);
    push_byte(8'd8); push_byte(8'd0); push_byte(8'd1); push_byte(8'd9); push_byte(8'd127);
    push_byte(8'd128); push_byte(8'd136); push_byte(8'd200); push_byte(8'd255);
    push_byte(8'h55);
    repeat (8) push_read();
    wait_idle();
    apb_write(rgbe_pkg::REG_MODE, 32'd0);
    push_rle_line(8, 8, 0);
    push_read();

    // width and height extremes, oversize width, zero width, raw width 1
    setup_image(16383, 32767, 1);
    push_byte(8'd2); push_byte(8'd2); push_byte(8'h3f); push_byte(8'hff); push_read();
    setup_image(0, 1, 1);
    push_byte(8'd7); push_read();
    setup_image(1, 1, 1);
    run_image(1, 1);

    // full-width line built from long runs, a few pixels read back
    setup_image(8192, 1, 1);
    no_gaps = 1; out_no_stall = 1;
    push_byte(8'd2); push_byte(8'd2); push_byte(8'h20); push_byte(8'h00);
    for (int pl = 0; pl < 4; pl++) begin
      repeat (64) begin
        push_byte(8'd255);
        push_byte(pick_value());
      end
      push_byte(8'(128 + 64));
      push_byte(pick_value());
    end
    repeat (4) push_read();
    wait_idle();
    no_gaps = 0; out_no_stall = 0;

    while (beats_sent < 850) begin
      case ($urandom_range(19))
        0, 1, 2: w = $urandom_range(7, 1);
        3, 4: w = $urandom_range(48, 25);
        default: w = $urandom_range(24, 8);
      endcase
      h = $urandom_range(3, 1);
      setup_image(w, h, $urandom_range(3) != 0);
      no_gaps = ($urandom_range(4) == 0);
      out_no_stall = ($urandom_range(4) == 0);
      run_image(w, h);
    end

    wait_idle();
    if (errors == 0 && expected_pixels.size() == 0) $display("rgbe_rle_scanline_decoder: match");
    else $display("rgbe_rle_scanline_decoder: mismatch");
    $finish;
  end

endmodule

### sim.f
rtl/rgbe_pkg.sv
rtl/rgbe_ram.sv
rtl/rgbe_rle_scanline_decoder.sv
tb/tb_rgbe_rle_scanline_decoder.sv
